@@ rtl/tcat_pkg.sv @@
package tcat_pkg;

   // Multiplier: one register of 33 x 33 limb products, then a registered
   // adder tree over a fixed 32 leaves, five levels deep.
   localparam int MUL_LEAVES = 32;
   localparam int MUL_LAT    = 6;

   // Edge, determinant and final word widths.
   localparam int EW   = 33;
   localparam int SQW  = 67;
   localparam int MW   = 67;
   localparam int NW   = 136;
   localparam int DW   = 102;
   localparam int DSW  = 206;
   localparam int NOMW = 280;

   localparam int PIPE_LAT = 4 * MUL_LAT + 4;

   localparam logic [NOMW-1:0] TINY_DIV = NOMW'(1000000000);
   localparam logic [NOMW-1:0] TINY_DEN =
      ((NOMW'(1) << 96) + TINY_DIV - NOMW'(1)) / TINY_DIV;
   localparam logic [NOMW-1:0] TINY_NOM =
      ((NOMW'(1) << 128) + TINY_DIV - NOMW'(1)) / TINY_DIV;

   localparam logic [3:0] ADDR_ALPHA = 4'h0;

   typedef enum logic [1:0] {
      VERDICT_REJECT = 2'd0,
      VERDICT_ACCEPT = 2'd1,
      VERDICT_SLIVER = 2'd2
   } verdict_type;

endpackage

@@ rtl/tcat_delay.sv @@
module tcat_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] sh_ff [N];

   always_ff @(posedge clock) begin
      if (en) begin
         sh_ff[0] <= d;
         for (int i = 1; i < N; i++) begin
            sh_ff[i] <= sh_ff[i-1];
         end
      end
   end

   assign q = sh_ff[N-1];

endmodule

@@ rtl/tcat_mul.sv @@
module tcat_mul #(
   parameter int AW = 33,
   parameter int BW = 33,
   parameter int PW = 66
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [AW-1:0] a,
   input  logic signed [BW-1:0] b,
   output logic signed [PW-1:0] p
);

   localparam int NA = (AW + 31) / 32;
   localparam int NB = (BW + 31) / 32;
   localparam int NP = NA * NB;

   logic signed [NA*32-1:0] a_x;
   logic signed [NB*32-1:0] b_x;
   logic signed [32:0]      al [NA];
   logic signed [32:0]      bl [NB];
   logic signed [65:0]      pp_ff [NP];
   logic signed [PW-1:0]    leaf [tcat_pkg::MUL_LEAVES];
   logic signed [PW-1:0]    node_ff [tcat_pkg::MUL_LEAVES-1];

   assign a_x = (NA*32)'(a);
   assign b_x = (NB*32)'(b);

   // Lower limbs are unsigned; only the top limb carries the sign.
   for (genvar i = 0; i < NA; i++) begin : g_al
      if (i == NA - 1) begin : g_top
         assign al[i] = {a_x[32*i+31], a_x[32*i+:32]};
      end else begin : g_low
         assign al[i] = {1'b0, a_x[32*i+:32]};
      end
   end

   for (genvar j = 0; j < NB; j++) begin : g_bl
      if (j == NB - 1) begin : g_top
         assign bl[j] = {b_x[32*j+31], b_x[32*j+:32]};
      end else begin : g_low
         assign bl[j] = {1'b0, b_x[32*j+:32]};
      end
   end

   for (genvar k = 0; k < NP; k++) begin : g_pp
      always_ff @(posedge clock) begin
         if (en) begin
            pp_ff[k] <= al[k/NB] * bl[k%NB];
         end
      end
   end

   for (genvar k = 0; k < tcat_pkg::MUL_LEAVES; k++) begin : g_leaf
      if (k < NP) begin : g_used
         assign leaf[k] = PW'(pp_ff[k]) <<< (32 * (k/NB + k%NB));
      end else begin : g_zero
         assign leaf[k] = '0;
      end
   end

   // Heap-ordered tree: node n sums nodes 2n+1 and 2n+2; on the bottom level those children are leaves.
   for (genvar n = 0; n < tcat_pkg::MUL_LEAVES - 1; n++) begin : g_node
      if (2*n + 1 >= tcat_pkg::MUL_LEAVES - 1) begin : g_bottom
         always_ff @(posedge clock) begin
            if (en) begin
               node_ff[n] <= leaf[2*n+1-(tcat_pkg::MUL_LEAVES-1)]
                           + leaf[2*n+2-(tcat_pkg::MUL_LEAVES-1)];
            end
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            if (en) begin
               node_ff[n] <= node_ff[2*n+1] + node_ff[2*n+2];
            end
         end
      end
   end

   assign p = node_ff[0];

endmodule

@@ rtl/tetra_circumradius_alpha_test.sv @@
// Channel  Direction  Handshake                 Payload
// req      in         req_valid / req_stall     req_p0_x .. req_p3_z (signed Q16.16)
// rsp      out        rsp_valid / rsp_stall     rsp_verdict (2 bits)
// csr      in         psel/penable/pwrite/pready  alpha_limit at byte address 0
//
// One word is accepted per cycle while req_stall is low. Its verdict passes through
// the edge register, four chained multipliers, three add stages between them and the
// output register.
// Synchronous active-high reset clears the valid bits, the skid flag and alpha_limit.
// A stalled result waits in the output register while one more word drains into a skid
// register; only then does req_stall rise.
module tetra_circumradius_alpha_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_p0_x,
   input  logic signed [31:0] req_p0_y,
   input  logic signed [31:0] req_p0_z,
   input  logic signed [31:0] req_p1_x,
   input  logic signed [31:0] req_p1_y,
   input  logic signed [31:0] req_p1_z,
   input  logic signed [31:0] req_p2_x,
   input  logic signed [31:0] req_p2_y,
   input  logic signed [31:0] req_p2_z,
   input  logic signed [31:0] req_p3_x,
   input  logic signed [31:0] req_p3_y,
   input  logic signed [31:0] req_p3_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_verdict,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   localparam int EW   = tcat_pkg::EW;
   localparam int SQW  = tcat_pkg::SQW;
   localparam int MW   = tcat_pkg::MW;
   localparam int NW   = tcat_pkg::NW;
   localparam int DW   = tcat_pkg::DW;
   localparam int DSW  = tcat_pkg::DSW;
   localparam int NOMW = tcat_pkg::NOMW;
   localparam int LAT  = tcat_pkg::MUL_LAT;
   localparam int PL   = tcat_pkg::PIPE_LAT;

   logic [63:0] alpha_ff;

   logic en;
   logic acc;
   logic [PL:1] v_ff;

   logic signed [31:0]    pt [4][3];
   logic signed [EW-1:0]  e_ff [3][3];
   logic [9*EW-1:0]       e_flat;
   logic [9*EW-1:0]       ed_flat;
   logic signed [EW-1:0]  ed [3][3];
   logic signed [2*EW-1:0] sqp [3][3];
   logic signed [SQW-1:0] sq_ff [3];
   logic signed [2*EW-1:0] mp [3][3];
   logic signed [2*EW-1:0] mq [3][3];
   logic signed [MW-1:0]  minor_ff [3][3];
   logic signed [MW+SQW-1:0] dp [3][3];
   logic signed [MW+EW-1:0]  gp [3];
   logic signed [NW-1:0]  n_ff [3];
   logic signed [DW-1:0]  den_ff;
   logic signed [2*NW-1:0] nsq [3];
   logic signed [2*DW-1:0] dsq;
   logic [NOMW-1:0]       nomin_ff;
   logic [DSW-1:0]        denom_ff;
   logic                  tiny_ff;
   logic signed [DSW+65-1:0] prod;
   logic [NOMW-1:0]       nomin_d;
   logic [0:0]            tiny_d;
   tcat_pkg::verdict_type verdict;

   logic                  rsp_valid_ff;
   tcat_pkg::verdict_type rsp_verdict_ff;
   logic                  skid_valid_ff;
   tcat_pkg::verdict_type skid_verdict_ff;
   logic                  fire;

   // Configuration.
   assign pready = 1'b1;
   assign prdata = (paddr == tcat_pkg::ADDR_ALPHA) ? alpha_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 64'd0;
      end else if (psel && penable && pwrite && paddr == tcat_pkg::ADDR_ALPHA) begin
         alpha_ff <= pwdata;
      end
   end

   // The whole pipeline advances unless the skid register is occupied.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign acc       = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PL-1:1], acc};
      end
   end

   assign pt[0] = '{req_p0_x, req_p0_y, req_p0_z};
   assign pt[1] = '{req_p1_x, req_p1_y, req_p1_z};
   assign pt[2] = '{req_p2_x, req_p2_y, req_p2_z};
   assign pt[3] = '{req_p3_x, req_p3_y, req_p3_z};

   // Edge vectors from corner 0.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               e_ff[c][k] <= EW'(pt[c+1][k]) - EW'(pt[0][k]);
            end
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_epack
      for (genvar k = 0; k < 3; k++) begin : g_k
         assign e_flat[EW*(3*c+k)+:EW] = e_ff[c][k];
         assign ed[c][k] = $signed(ed_flat[EW*(3*c+k)+:EW]);
      end
   end

   tcat_delay #(.W(9*EW), .N(LAT + 1)) u_edge_dly (
      .clock (clock),
      .en    (en),
      .d     (e_flat),
      .q     (ed_flat)
   );

   // Squared edge lengths.
   for (genvar c = 0; c < 3; c++) begin : g_sq
      for (genvar k = 0; k < 3; k++) begin : g_k
         tcat_mul #(.AW(EW), .BW(EW), .PW(2*EW)) u_mul (
            .clock (clock),
            .en    (en),
            .a     (e_ff[c][k]),
            .b     (e_ff[c][k]),
            .p     (sqp[c][k])
         );
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[c] <= SQW'(sqp[c][0]) + SQW'(sqp[c][1]) + SQW'(sqp[c][2]);
         end
      end
   end

   // 2x2 minors. Set s takes columns (y,z), (x,z) or (x,y); the (x,y) set
   // also serves the volume determinant.
   for (genvar s = 0; s < 3; s++) begin : g_set
      localparam int U = (s == 0) ? 1 : 0;
      localparam int V = (s == 2) ? 1 : 2;
      for (genvar m = 0; m < 3; m++) begin : g_minor
         localparam int R1 = (m == 2) ? 1 : 0;
         localparam int R2 = (m == 1) ? 1 : 2;
         tcat_mul #(.AW(EW), .BW(EW), .PW(2*EW)) u_mp (
            .clock (clock),
            .en    (en),
            .a     (e_ff[R1][U]),
            .b     (e_ff[R2][V]),
            .p     (mp[s][m])
         );
         tcat_mul #(.AW(EW), .BW(EW), .PW(2*EW)) u_mq (
            .clock (clock),
            .en    (en),
            .a     (e_ff[R2][U]),
            .b     (e_ff[R1][V]),
            .p     (mq[s][m])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               minor_ff[s][m] <= MW'(mp[s][m]) - MW'(mq[s][m]);
            end
         end
      end
   end

   // Cofactor expansion along the third column; the minor of rows 0 and 2
   // enters with a negative sign.
   for (genvar d = 0; d < 3; d++) begin : g_det
      for (genvar m = 0; m < 3; m++) begin : g_term
         localparam int RR = (m == 0) ? 1 : ((m == 1) ? 2 : 0);
         tcat_mul #(.AW(MW), .BW(SQW), .PW(MW+SQW)) u_mul (
            .clock (clock),
            .en    (en),
            .a     (minor_ff[d][m]),
            .b     (sq_ff[RR]),
            .p     (dp[d][m])
         );
      end
      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[d] <= NW'(dp[d][1]) - NW'(dp[d][0]) + NW'(dp[d][2]);
         end
      end
   end

   for (genvar m = 0; m < 3; m++) begin : g_vol
      localparam int RR = (m == 0) ? 1 : ((m == 1) ? 2 : 0);
      tcat_mul #(.AW(MW), .BW(EW), .PW(MW+EW)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (minor_ff[2][m]),
         .b     (ed[RR][2]),
         .p     (gp[m])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff <= DW'(gp[1]) - DW'(gp[0]) + DW'(gp[2]);
      end
   end

   // Squared numerator and denominator.
   for (genvar d = 0; d < 3; d++) begin : g_nsq
      tcat_mul #(.AW(NW), .BW(NW), .PW(2*NW)) u_mul (
         .clock (clock),
         .en    (en),
         .a     (n_ff[d]),
         .b     (n_ff[d]),
         .p     (nsq[d])
      );
   end

   tcat_mul #(.AW(DW), .BW(DW), .PW(2*DW)) u_dsq (
      .clock (clock),
      .en    (en),
      .a     (den_ff),
      .b     (den_ff),
      .p     (dsq)
   );

   // All squares are nonnegative, so they are carried on as unsigned words.
   always_ff @(posedge clock) begin
      if (en) begin
         nomin_ff <= NOMW'($unsigned(nsq[0])) + NOMW'($unsigned(nsq[1]))
                   + NOMW'($unsigned(nsq[2]));
         denom_ff <= {$unsigned(dsq), 2'b00};
         tiny_ff  <= (NOMW'(denom_ff) < tcat_pkg::TINY_DEN)
                  && (nomin_ff < tcat_pkg::TINY_NOM);
      end
   end

   tcat_mul #(.AW(65), .BW(DSW+1), .PW(DSW+65)) u_alpha (
      .clock (clock),
      .en    (en),
      .a     ($signed({1'b0, alpha_ff})),
      .b     ($signed({1'b0, denom_ff})),
      .p     (prod)
   );

   tcat_delay #(.W(NOMW), .N(LAT)) u_nomin_dly (
      .clock (clock),
      .en    (en),
      .d     (nomin_ff),
      .q     (nomin_d)
   );

   tcat_delay #(.W(1), .N(LAT - 1)) u_tiny_dly (
      .clock (clock),
      .en    (en),
      .d     (tiny_ff),
      .q     (tiny_d)
   );

   always_comb begin
      if (tiny_d[0]) begin
         verdict = tcat_pkg::VERDICT_SLIVER;
      end else if (nomin_d < NOMW'($unsigned(prod))) begin
         verdict = tcat_pkg::VERDICT_ACCEPT;
      end else begin
         verdict = tcat_pkg::VERDICT_REJECT;
      end
   end

   // Output register with one skid word behind it.
   assign fire = v_ff[PL] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp_stall) begin
         if (fire) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_stall) begin
         if (fire) begin
            skid_verdict_ff <= verdict;
         end
      end else if (skid_valid_ff) begin
         rsp_verdict_ff <= skid_verdict_ff;
      end else if (fire) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

endmodule
